// ----- rtl/core/fixed_point_alu_unit_macros.svh -----
// ----------------------------------------------------------------------------
// fixed_point_alu_unit assertion macros
// shared property forms used by the alu top level
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define FPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fixed_point_alu_unit same-cycle check failed");

// next-cycle implication, reset masks the check
`define FPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fixed_point_alu_unit next-cycle check failed");

`endif

// ----- rtl/core/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// shared widths, opcodes and stage payload type of the fixed-point alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 4;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
  localparam logic [OP_W-1:0] OP_INC  = 4'd4;
  localparam logic [OP_W-1:0] OP_DEC  = 4'd5;
  localparam logic [OP_W-1:0] OP_MIN  = 4'd6;
  localparam logic [OP_W-1:0] OP_MAX  = 4'd7;
  localparam logic [OP_W-1:0] OP_ITOF = 4'd8;
  localparam logic [OP_W-1:0] OP_FTOI = 4'd9;

  // result and flags that ride alongside the divider
  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              is_div;
    logic              neg;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
  } side_t;

endpackage

// ----- rtl/core/fpa_front.sv -----
// ----------------------------------------------------------------------------
// fpa_front
// first stage: decode, the non-multiply non-divide ops, 32x32 product and divider setup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DW        = DATA_W + FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [OP_W-1:0]          opcode,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output logic                     out_valid,
  output side_t                    out_side,
  output logic [DW-1:0]            out_dividend,
  output logic [DATA_W-1:0]        out_divisor
);

  logic                         valid;
  logic signed [2*DATA_W-1:0]   prod;
  logic                         is_mul;
  side_t                        side;
  logic [DW-1:0]                dividend;
  logic [DATA_W-1:0]            divisor;

  side_t                        side_next;
  logic [DATA_W-1:0]            abs_a;
  logic [DATA_W-1:0]            abs_b;

  always_comb begin
    abs_a = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
    abs_b = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
    side_next.lt     = operand_a < operand_b;
    side_next.eq     = operand_a == operand_b;
    side_next.gt     = operand_a > operand_b;
    side_next.is_div = (opcode == OP_DIV) && (operand_b != '0);
    side_next.dz     = (opcode == OP_DIV) && (operand_b == '0);
    side_next.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
    case (opcode)
      OP_ADD:  side_next.res = operand_a + operand_b;
      OP_SUB:  side_next.res = operand_a - operand_b;
      OP_INC:  side_next.res = operand_a + 1'b1;
      OP_DEC:  side_next.res = operand_a - 1'b1;
      OP_MIN:  side_next.res = (operand_a < operand_b) ? operand_a : operand_b;
      OP_MAX:  side_next.res = (operand_a > operand_b) ? operand_a : operand_b;
      OP_ITOF: side_next.res = operand_a << FRAC_BITS;
      OP_FTOI: side_next.res = operand_a >>> FRAC_BITS;
      default: side_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ce) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prod     <= operand_a * operand_b;
      is_mul   <= opcode == OP_MUL;
      side     <= side_next;
      dividend <= DW'(abs_a) << FRAC_BITS;
      divisor  <= abs_b;
    end
  end

  // multiply result is a fixed slice of the registered product
  always_comb begin
    out_side = side;
    if (is_mul) begin
      out_side.res = prod[FRAC_BITS +: DATA_W];
    end
  end

  assign out_valid    = valid;
  assign out_dividend = dividend;
  assign out_divisor  = divisor;

endmodule

// ----- rtl/core/fpa_div_stage.sv -----
// ----------------------------------------------------------------------------
// fpa_div_stage
// one restoring-division step: one quotient bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_div_stage import fpa_pkg::*; #(
  parameter int DW = DATA_W + FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [DATA_W-1:0] in_rem,
  input  logic [DW-1:0]     in_num,
  input  logic [DATA_W-1:0] in_div,
  output logic              out_valid,
  output side_t             out_side,
  output logic [DATA_W-1:0] out_rem,
  output logic [DW-1:0]     out_num,
  output logic [DATA_W-1:0] out_div
);

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] rem_next;
  logic [DW-1:0]     num_next;

  always_comb begin
    trial    = {in_rem, in_num[DW-1]};
    diff     = trial - {1'b0, in_div};
    ge       = trial >= {1'b0, in_div};
    rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    // dividend bits leave at the top, quotient bits enter at the bottom
    num_next = {in_num[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_side <= in_side;
      out_rem  <= rem_next;
      out_num  <= num_next;
      out_div  <= in_div;
    end
  end

endmodule

// ----- rtl/core/fpa_div.sv -----
// ----------------------------------------------------------------------------
// fpa_div
// pipelined unsigned divider, DW stages, carries the side payload along
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_div import fpa_pkg::*; #(
  parameter int DW = DATA_W + FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [DW-1:0]     in_dividend,
  input  logic [DATA_W-1:0] in_divisor,
  output logic              out_valid,
  output side_t             out_side,
  output logic [DW-1:0]     out_quot
);

  logic              v   [DW+1];
  side_t             sd  [DW+1];
  logic [DATA_W-1:0] rm  [DW+1];
  logic [DW-1:0]     nm  [DW+1];
  logic [DATA_W-1:0] dv  [DW+1];

  assign v[0]  = in_valid;
  assign sd[0] = in_side;
  assign rm[0] = '0;
  assign nm[0] = in_dividend;
  assign dv[0] = in_divisor;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    fpa_div_stage #(.DW(DW)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (v[k]),
      .in_side   (sd[k]),
      .in_rem    (rm[k]),
      .in_num    (nm[k]),
      .in_div    (dv[k]),
      .out_valid (v[k+1]),
      .out_side  (sd[k+1]),
      .out_rem   (rm[k+1]),
      .out_num   (nm[k+1]),
      .out_div   (dv[k+1])
    );
  end

  assign out_valid = v[DW];
  assign out_side  = sd[DW];
  assign out_quot  = nm[DW];

endmodule

// ----- rtl/core/fixed_point_alu_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// signed fixed-point alu: add, sub, mul, div, inc, dec, min, max, conversions
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ stream (opcode in s_tuser, operands in
// s_tdata) and one result per item leaves on the m_ stream in order.
// The path from input transfer to m_tvalid runs through one front stage
// holding the 32x32 multiplier, one divider stage per quotient bit
// (32 + FRAC_BITS), and the output register. Every opcode takes the same
// path, so one item is taken per cycle while the output keeps flowing.
// A one-entry skid register behind the output lets the pipeline keep
// moving while a result waits; once the skid is full, s_tready drops and
// the whole pipeline holds in place until m_tready frees the skid.
// Synchronous reset empties the pipeline, the output and the skid register.
// Divide by zero returns 0 with the divide_by_zero flag; unused opcodes
// return 0 with the comparison flags still set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fixed_point_alu_unit_macros.svh"

module fixed_point_alu_unit import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a, operand_b
  input  logic [3:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result_value, a_less_b, a_equal_b,
                                 // a_greater_b, divide_by_zero, zero pad
);

  localparam int DW  = DATA_W + FRAC_BITS;
  localparam int RES_W = DATA_W + 4;

  logic              ce;
  logic              f_valid;
  side_t             f_side;
  logic [DW-1:0]     f_dividend;
  logic [DATA_W-1:0] f_divisor;
  logic              d_valid;
  side_t             d_side;
  logic [DW-1:0]     d_quot;
  logic [DATA_W-1:0] q32;
  logic [RES_W-1:0]  last_data;

  logic              out_valid;
  logic [RES_W-1:0]  out_data;
  logic              skid_valid;
  logic [RES_W-1:0]  skid_data;

  assign ce       = !skid_valid;
  assign s_tready = ce;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (s_tvalid),
    .opcode       (s_tuser),
    .operand_a    (s_tdata[31:0]),
    .operand_b    (s_tdata[63:32]),
    .out_valid    (f_valid),
    .out_side     (f_side),
    .out_dividend (f_dividend),
    .out_divisor  (f_divisor)
  );

  fpa_div #(.DW(DW)) u_div (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in_valid    (f_valid),
    .in_side     (f_side),
    .in_dividend (f_dividend),
    .in_divisor  (f_divisor),
    .out_valid   (d_valid),
    .out_side    (d_side),
    .out_quot    (d_quot)
  );

  // quotient is truncated to 32 bits before the sign is applied
  always_comb begin
    q32 = d_quot[DATA_W-1:0];
    last_data = {d_side.dz, d_side.gt, d_side.eq, d_side.lt, d_side.res};
    if (d_side.is_div) begin
      last_data[DATA_W-1:0] = d_side.neg ? (~q32 + 1'b1) : q32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= d_valid;
      end
    end else if (d_valid && ce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : last_data;
    end else if (d_valid && ce) begin
      skid_data <= last_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_data};

  `FPA_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `FPA_ASSERT_NEXT(a_skid_holds, skid_valid && !m_tready, skid_valid && out_valid)
  `FPA_ASSERT_NOW(a_flags_onehot, m_tvalid, $onehot(m_tdata[34:32]))
  `FPA_ASSERT_NOW(a_dz_zero, m_tvalid && m_tdata[35], m_tdata[31:0] == 32'd0)

endmodule
